[rtl/core/tas_pkg.sv]
// Shared types and constants for the timed actuator sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tas_pkg;

    // Field widths fixed by the stream format
    localparam int AMT_BITS   = 8;
    localparam int CFG_BITS   = 16;
    localparam int PROD_BITS  = AMT_BITS + CFG_BITS;
    localparam int MODE_BITS  = 2;
    localparam int PHASE_BITS = 4;
    localparam int OUT_PUMPS  = 4;

    // Command kinds carried in the input word
    localparam logic [MODE_BITS-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_START = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_STOP  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCALE = 2'd0;
    localparam logic [1:0] CFG_HEAD  = 2'd1;
    localparam logic [1:0] CFG_DRIP  = 2'd2;

    // Configuration reset values
    localparam logic [CFG_BITS-1:0] SCALE_RST = 16'd1000;
    localparam logic [CFG_BITS-1:0] HEAD_RST  = 16'd1800;
    localparam logic [CFG_BITS-1:0] DRIP_RST  = 16'd2000;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_IDLE        = 4'd0,
        PH_START       = 4'd1,
        PH_START_LOWER = 4'd2,
        PH_LOWER       = 4'd3,
        PH_START_PUMP  = 4'd4,
        PH_PUMP        = 4'd5,
        PH_START_MIX   = 4'd6,
        PH_MIX         = 4'd7,
        PH_START_DRIP  = 4'd8,
        PH_DRIP        = 4'd9,
        PH_START_RAISE = 4'd10,
        PH_RAISE       = 4'd11
    } phase_t;

    // Per-word command strobes to the actuator lanes
    typedef struct packed {
        logic tick;   // millisecond tick being applied
        logic stop;   // stop command: switch everything off
        logic load;   // accepted start: latch durations
        logic go;     // phase machine requests the pumps this tick
    } tas_cmd_t;

endpackage

[rtl/core/tas_scale.sv]
// Amount-to-duration scaling: 8-bit amount times 16-bit unit, saturated.
// Depends on tas_pkg for field widths.
`timescale 1ns / 1ps

module tas_scale #(
    parameter int TIMER_BITS = 24
) (
    input  logic [tas_pkg::AMT_BITS-1:0] amount,
    input  logic [tas_pkg::CFG_BITS-1:0] scale,
    output logic [TIMER_BITS-1:0]        duration
);
    import tas_pkg::*;

    logic [PROD_BITS-1:0] prod;

    assign prod = PROD_BITS'(amount) * PROD_BITS'(scale);

    generate
        if (TIMER_BITS >= PROD_BITS) begin : g_wide
            assign duration = TIMER_BITS'(prod);
        end
        else begin : g_sat
            // clamp to the largest count the timer holds
            assign duration = (|prod[PROD_BITS-1:TIMER_BITS]) ? '1 : prod[TIMER_BITS-1:0];
        end
    endgenerate

endmodule

[rtl/core/tas_pump.sv]
// One pump lane: request/active flags, latched duration and countdown.
// Depends on tas_pkg for the command struct.
`timescale 1ns / 1ps

module tas_pump #(
    parameter int TIMER_BITS = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tas_pkg::tas_cmd_t        cmd,
    input  logic [TIMER_BITS-1:0]    duration,
    output logic                     active_next,
    output logic                     busy
);
    import tas_pkg::*;

    logic                  req_reg, req_next;
    logic                  act_reg, act_next;
    logic [TIMER_BITS-1:0] dur_reg;
    logic [TIMER_BITS-1:0] rem_reg, rem_next;
    logic                  req_now;

    always_comb
    begin
        req_next = req_reg;
        act_next = act_reg;
        rem_next = rem_reg;
        req_now  = req_reg | cmd.go;
        if (cmd.stop)
        begin
            req_next = 1'b0;
            act_next = 1'b0;
        end
        else if (cmd.tick)
        begin
            req_next = req_now;
            if (req_now)
            begin
                if (!act_reg)
                begin
                    act_next = 1'b1;
                    rem_next = dur_reg;
                end
                else if (rem_reg == '0)
                begin
                    act_next = 1'b0;
                    req_next = 1'b0;
                end
                else
                begin
                    rem_next = rem_reg - TIMER_BITS'(1);
                end
            end
            else
            begin
                act_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= 1'b0;
            act_reg <= 1'b0;
        end
        else
        begin
            req_reg <= req_next;
            act_reg <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            dur_reg <= duration;
        end
    end

    assign active_next = act_next;
    assign busy        = act_reg | req_reg;

endmodule

[rtl/core/timed_actuator_sequencer.sv]
// Top level of the timed actuator sequencer: stream ports, configuration,
// phase machine, head and mixer timers. Uses tas_pkg, tas_scale, tas_pump.
`timescale 1ns / 1ps

// Channel   | Direction | Payload (lowest bit first)
// ----------+-----------+---------------------------------------------------
// s_*       | in        | tuser: mode[1:0]; tdata: pump_amount_0..3, mix_amount
// m_*       | out       | tdata: phase, pumps_on, mixer_on, head_up, head_down,
//           |           |        start_rejected
// cfg_*     | in        | write enable, register index, 16-bit data
//
// One word is taken every clock while the result side keeps up; a result
// passes through the input register, then the result register.
// All of a word's work fits between those two registers: five 8x16 scaling
// multipliers on a start, counter steps on a tick.
// Reset clears control state and loads the configuration defaults.
// A stalled result holds in the output register while the next word waits in
// the input register; input ready drops only when both are full.

module timed_actuator_sequencer #(
    parameter int NUM_PUMPS  = 4,
    parameter int TIMER_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pump_amount_0, pump_amount_1, pump_amount_2,
                                   // pump_amount_3, mix_amount (8 bits each)
    input  logic [1:0]  s_tuser,   // mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // phase[3:0], pumps_on[7:4], mixer_on[8],
                                   // head_up[9], head_down[10], start_rejected[11],
                                   // zero fill [15:12]
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import tas_pkg::*;

    // configuration registers
    logic [CFG_BITS-1:0] scale_reg, head_ticks_reg, drip_ticks_reg;

    // input register
    logic                      in_vld_reg;
    logic [MODE_BITS-1:0]      in_mode_reg;
    logic [5*AMT_BITS-1:0]     in_amt_reg;

    // output register
    logic                      out_vld_reg;
    logic [15:0]               out_data_reg;

    logic out_free, move;
    tas_cmd_t cmd;

    // sequence state
    phase_t phase_reg, phase_next;
    logic   up_en_reg, down_en_reg, up_run_reg, down_run_reg;
    logic   up_en_next, down_en_next, up_run_next, down_run_next;
    logic   up_en_ph, down_en_ph, mix_en_ph;
    logic   mix_en_reg, mix_run_reg, mix_en_next, mix_run_next;
    logic [CFG_BITS-1:0]   head_rem_reg, head_rem_next;
    logic [CFG_BITS-1:0]   drip_rem_reg, drip_rem_next;
    logic [TIMER_BITS-1:0] mix_dur_reg, mix_rem_reg, mix_rem_next, mix_dur_scaled;
    logic                  rejected;

    // pump lanes
    logic [NUM_PUMPS-1:0] pump_act_next, pump_busy;
    logic [OUT_PUMPS-1:0] pumps_on;

    //------------------------------------------------------------------
    // Handshake: advance when the input register holds a word and the
    // output register is free or being emptied this cycle.
    //------------------------------------------------------------------
    assign out_free = !out_vld_reg || m_tready;
    assign move     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (move)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg <= s_tuser;
            in_amt_reg  <= s_tdata;
        end
        if (move)
        begin
            out_data_reg <= {4'b0000, rejected, down_run_next, up_run_next,
                             mix_run_next, pumps_on, phase_next};
        end
    end

    //------------------------------------------------------------------
    // Configuration writes; unknown indexes are dropped.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= SCALE_RST;
            head_ticks_reg <= HEAD_RST;
            drip_ticks_reg <= DRIP_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_SCALE: scale_reg      <= cfg_wdata;
                CFG_HEAD:  head_ticks_reg <= cfg_wdata;
                CFG_DRIP:  drip_ticks_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Command decode for the word being retired this cycle.
    //------------------------------------------------------------------
    always_comb
    begin
        cmd.tick = move && (in_mode_reg == MODE_TICK);
        cmd.stop = move && (in_mode_reg == MODE_STOP);
        cmd.load = move && (in_mode_reg == MODE_START) && (phase_reg == PH_IDLE);
        cmd.go   = cmd.tick && (phase_reg == PH_START_PUMP);
    end

    assign rejected = move && (in_mode_reg == MODE_START) && (phase_reg != PH_IDLE);

    //------------------------------------------------------------------
    // Phase machine. On a tick it runs first and may raise the drive
    // enables that the head and mixer updates below then see.
    //------------------------------------------------------------------
    always_comb
    begin
        phase_next    = phase_reg;
        up_en_ph      = up_en_reg;
        down_en_ph    = down_en_reg;
        mix_en_ph     = mix_en_reg;
        drip_rem_next = drip_rem_reg;
        if (cmd.tick)
        begin
            case (phase_reg)
                PH_IDLE:        ;
                PH_START:       phase_next = PH_START_LOWER;
                PH_START_LOWER:
                begin
                    down_en_ph = 1'b1;
                    phase_next = PH_LOWER;
                end
                PH_LOWER:
                begin
                    if (!down_run_reg && !down_en_reg)
                    begin
                        phase_next = PH_START_PUMP;
                    end
                end
                PH_START_PUMP:  phase_next = PH_PUMP;
                PH_PUMP:
                begin
                    if (!(|pump_busy))
                    begin
                        phase_next = PH_START_MIX;
                    end
                end
                PH_START_MIX:
                begin
                    mix_en_ph  = 1'b1;
                    phase_next = PH_MIX;
                end
                PH_MIX:
                begin
                    if (!mix_run_reg && !mix_en_reg)
                    begin
                        phase_next = PH_START_DRIP;
                    end
                end
                PH_START_DRIP:
                begin
                    drip_rem_next = drip_ticks_reg;
                    phase_next    = PH_DRIP;
                end
                PH_DRIP:
                begin
                    if (drip_rem_reg == '0)
                    begin
                        phase_next = PH_START_RAISE;
                    end
                    else
                    begin
                        drip_rem_next = drip_rem_reg - CFG_BITS'(1);
                    end
                end
                PH_START_RAISE:
                begin
                    up_en_ph   = 1'b1;
                    phase_next = PH_RAISE;
                end
                PH_RAISE:
                begin
                    if (!up_run_reg && !up_en_reg)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:        phase_next = PH_IDLE;
            endcase
        end
        else if (cmd.load)
        begin
            phase_next = PH_START_LOWER;
        end
        else if (cmd.stop)
        begin
            phase_next = PH_START_RAISE;
        end
    end

    //------------------------------------------------------------------
    // Head and mixer timers, one update each per tick.
    //------------------------------------------------------------------
    always_comb
    begin
        up_en_next    = up_en_reg;
        down_en_next  = down_en_reg;
        up_run_next   = up_run_reg;
        down_run_next = down_run_reg;
        head_rem_next = head_rem_reg;
        mix_en_next   = mix_en_reg;
        mix_run_next  = mix_run_reg;
        mix_rem_next  = mix_rem_reg;
        if (cmd.stop)
        begin
            up_en_next    = 1'b0;
            down_en_next  = 1'b0;
            up_run_next   = 1'b0;
            down_run_next = 1'b0;
            mix_en_next   = 1'b0;
            mix_run_next  = 1'b0;
        end
        else if (cmd.tick)
        begin
            up_en_next   = up_en_ph;
            down_en_next = down_en_ph;
            if (up_en_ph || down_en_ph)
            begin
                if (up_en_ph && down_en_ph)
                begin
                    // conflicting directions: cancel both
                    up_en_next    = 1'b0;
                    down_en_next  = 1'b0;
                    up_run_next   = 1'b0;
                    down_run_next = 1'b0;
                end
                else if (!(up_run_reg || down_run_reg))
                begin
                    up_run_next   = up_en_ph;
                    down_run_next = down_en_ph;
                    head_rem_next = head_ticks_reg;
                end
                else if (head_rem_reg == '0)
                begin
                    up_en_next    = 1'b0;
                    down_en_next  = 1'b0;
                    up_run_next   = 1'b0;
                    down_run_next = 1'b0;
                end
                else
                begin
                    head_rem_next = head_rem_reg - CFG_BITS'(1);
                end
            end
            else
            begin
                up_run_next   = 1'b0;
                down_run_next = 1'b0;
            end

            mix_en_next = mix_en_ph;
            if (mix_en_ph)
            begin
                if (!mix_run_reg)
                begin
                    mix_run_next = 1'b1;
                    mix_rem_next = mix_dur_reg;
                end
                else if (mix_rem_reg == '0)
                begin
                    mix_en_next  = 1'b0;
                    mix_run_next = 1'b0;
                end
                else
                begin
                    mix_rem_next = mix_rem_reg - TIMER_BITS'(1);
                end
            end
            else
            begin
                mix_run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            up_en_reg    <= 1'b0;
            down_en_reg  <= 1'b0;
            up_run_reg   <= 1'b0;
            down_run_reg <= 1'b0;
            mix_en_reg   <= 1'b0;
            mix_run_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            up_en_reg    <= up_en_next;
            down_en_reg  <= down_en_next;
            up_run_reg   <= up_run_next;
            down_run_reg <= down_run_next;
            mix_en_reg   <= mix_en_next;
            mix_run_reg  <= mix_run_next;
        end
    end

    // counters are loaded before they are read
    always_ff @(posedge clk)
    begin
        head_rem_reg <= head_rem_next;
        drip_rem_reg <= drip_rem_next;
        mix_rem_reg  <= mix_rem_next;
        if (cmd.load)
        begin
            mix_dur_reg <= mix_dur_scaled;
        end
    end

    tas_scale #(
        .TIMER_BITS (TIMER_BITS)
    ) u_mix_scale (
        .amount   (in_amt_reg[4*AMT_BITS +: AMT_BITS]),
        .scale    (scale_reg),
        .duration (mix_dur_scaled)
    );

    //------------------------------------------------------------------
    // Pump lanes. Only the first four carry an amount; the rest load zero.
    //------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < NUM_PUMPS; gi = gi + 1)
        begin : g_pump
            logic [TIMER_BITS-1:0] lane_dur;

            if (gi < OUT_PUMPS)
            begin : g_amt
                tas_scale #(
                    .TIMER_BITS (TIMER_BITS)
                ) u_scale (
                    .amount   (in_amt_reg[gi*AMT_BITS +: AMT_BITS]),
                    .scale    (scale_reg),
                    .duration (lane_dur)
                );
            end
            else
            begin : g_zero
                assign lane_dur = '0;
            end

            tas_pump #(
                .TIMER_BITS (TIMER_BITS)
            ) u_pump (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .duration    (lane_dur),
                .active_next (pump_act_next[gi]),
                .busy        (pump_busy[gi])
            );
        end

        for (gi = 0; gi < OUT_PUMPS; gi = gi + 1)
        begin : g_pumps_on
            if (gi < NUM_PUMPS)
            begin : g_lane
                assign pumps_on[gi] = pump_act_next[gi];
            end
            else
            begin : g_none
                assign pumps_on[gi] = 1'b0;
            end
        end
    endgenerate

endmodule

[tb/recipe_check_pkg.sv]
// Status predictor and scoreboard for the timed actuator sequencer testbench.
// Depends on tas_pkg for field widths, command kinds, register indexes and phases.
`timescale 1ns / 1ps

package recipe_check_pkg;
    import tas_pkg::*;

    localparam int TICK_BITS = 24;
    localparam logic [31:0] TICK_MAX = (32'd1 << TICK_BITS) - 32'd1;

    // The fourth command kind has no meaning; the block must leave its state alone
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic                 rejected;
        logic                 head_down;
        logic                 head_up;
        logic                 mixer_on;
        logic [OUT_PUMPS-1:0] pumps_on;
        phase_t               phase;
    } status_t;

    class recipe_scoreboard;
        status_t     awaited_status[$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned starts_taken;
        int unsigned starts_refused;
        int unsigned stops_seen;
        int unsigned recipes_done;

        logic [CFG_BITS-1:0]  unit_scale;
        logic [CFG_BITS-1:0]  travel_ticks;
        logic [CFG_BITS-1:0]  drip_ticks;

        phase_t               phase;
        logic [OUT_PUMPS-1:0] pump_req;
        logic [OUT_PUMPS-1:0] pump_run;
        logic [TICK_BITS-1:0] pump_len[OUT_PUMPS];
        logic [TICK_BITS-1:0] pump_left[OUT_PUMPS];
        logic [TICK_BITS-1:0] mix_len;
        logic [TICK_BITS-1:0] mix_left;
        logic                 mix_en, mix_run;
        logic                 up_en, down_en, up_run, down_run;
        logic [CFG_BITS-1:0]  travel_left;
        logic [CFG_BITS-1:0]  drip_left;

        function new();
            int i;
            mismatches     = 0;
            results_seen   = 0;
            starts_taken   = 0;
            starts_refused = 0;
            stops_seen     = 0;
            recipes_done   = 0;
            unit_scale     = SCALE_RST;
            travel_ticks   = HEAD_RST;
            drip_ticks     = DRIP_RST;
            phase          = PH_IDLE;
            for (i = 0; i < OUT_PUMPS; i++)
            begin
                pump_len[i]  = '0;
                pump_left[i] = '0;
            end
            mix_len     = '0;
            mix_left    = '0;
            travel_left = '0;
            drip_left   = '0;
            switch_all_off();
        endfunction

        function void set_register(logic [1:0] index, logic [CFG_BITS-1:0] value);
            case (index)
                CFG_SCALE: unit_scale   = value;
                CFG_HEAD:  travel_ticks = value;
                CFG_DRIP:  drip_ticks   = value;
                default:   ;
            endcase
        endfunction

        function int unsigned pending();
            return awaited_status.size();
        endfunction

        // Amount times scale, clamped to what the duration counters can hold
        function logic [TICK_BITS-1:0] amount_ticks(logic [AMT_BITS-1:0] amount);
            logic [31:0] product;
            product = 32'(amount) * 32'(unit_scale);
            if (product > TICK_MAX)
                return TICK_MAX[TICK_BITS-1:0];
            return product[TICK_BITS-1:0];
        endfunction

        function void switch_all_off();
            pump_req = '0;
            pump_run = '0;
            mix_en   = 1'b0;
            mix_run  = 1'b0;
            up_en    = 1'b0;
            up_run   = 1'b0;
            down_en  = 1'b0;
            down_run = 1'b0;
        endfunction

        function void advance_phase();
            case (phase)
                PH_IDLE:        ;
                PH_START:       phase = PH_START_LOWER;
                PH_START_LOWER:
                begin
                    down_en = 1'b1;
                    phase   = PH_LOWER;
                end
                PH_LOWER:
                    if (!down_run && !down_en)
                        phase = PH_START_PUMP;
                PH_START_PUMP:
                begin
                    pump_req = '1;
                    phase    = PH_PUMP;
                end
                PH_PUMP:
                    if (pump_req == '0 && pump_run == '0)
                        phase = PH_START_MIX;
                PH_START_MIX:
                begin
                    mix_en = 1'b1;
                    phase  = PH_MIX;
                end
                PH_MIX:
                    if (!mix_run && !mix_en)
                        phase = PH_START_DRIP;
                PH_START_DRIP:
                begin
                    drip_left = drip_ticks;
                    phase     = PH_DRIP;
                end
                PH_DRIP:
                    if (drip_left == '0)
                        phase = PH_START_RAISE;
                    else
                        drip_left = drip_left - 1'b1;
                PH_START_RAISE:
                begin
                    up_en = 1'b1;
                    phase = PH_RAISE;
                end
                PH_RAISE:
                    if (!up_run && !up_en)
                    begin
                        phase = PH_IDLE;
                        recipes_done++;
                    end
                default:        phase = PH_IDLE;
            endcase
        endfunction

        function void step_pumps();
            int i;
            for (i = 0; i < OUT_PUMPS; i++)
            begin
                if (pump_req[i])
                begin
                    if (!pump_run[i])
                    begin
                        pump_run[i]  = 1'b1;
                        pump_left[i] = pump_len[i];
                    end
                    else if (pump_left[i] == '0)
                    begin
                        pump_run[i] = 1'b0;
                        pump_req[i] = 1'b0;
                    end
                    else
                        pump_left[i] = pump_left[i] - 1'b1;
                end
                else
                    pump_run[i] = 1'b0;
            end
        endfunction

        function void step_head_and_mixer();
            if (up_en || down_en)
            begin
                if ((up_en && down_en) || ((up_run || down_run) && travel_left == '0))
                begin
                    up_en    = 1'b0;
                    down_en  = 1'b0;
                    up_run   = 1'b0;
                    down_run = 1'b0;
                end
                else if (!(up_run || down_run))
                begin
                    up_run      = up_en;
                    down_run    = down_en;
                    travel_left = travel_ticks;
                end
                else
                    travel_left = travel_left - 1'b1;
            end
            else
            begin
                up_run   = 1'b0;
                down_run = 1'b0;
            end

            if (mix_en)
            begin
                if (!mix_run)
                begin
                    mix_run  = 1'b1;
                    mix_left = mix_len;
                end
                else if (mix_left == '0)
                begin
                    mix_en  = 1'b0;
                    mix_run = 1'b0;
                end
                else
                    mix_left = mix_left - 1'b1;
            end
            else
                mix_run = 1'b0;
        endfunction

        // Apply one accepted input word and queue the status it must produce
        function void note_word(logic [MODE_BITS-1:0] mode, logic [39:0] amounts);
            status_t s;
            int      i;
            s = '0;
            case (mode)
                MODE_TICK:
                begin
                    advance_phase();
                    step_pumps();
                    step_head_and_mixer();
                end
                MODE_START:
                    if (phase == PH_IDLE)
                    begin
                        for (i = 0; i < OUT_PUMPS; i++)
                            pump_len[i] = amount_ticks(amounts[AMT_BITS*i +: AMT_BITS]);
                        mix_len = amount_ticks(amounts[AMT_BITS*OUT_PUMPS +: AMT_BITS]);
                        phase   = PH_START_LOWER;
                        starts_taken++;
                    end
                    else
                    begin
                        s.rejected = 1'b1;
                        starts_refused++;
                    end
                MODE_STOP:
                begin
                    switch_all_off();
                    phase = PH_START_RAISE;
                    stops_seen++;
                end
                default: ;
            endcase
            s.phase     = phase;
            s.pumps_on  = pump_run;
            s.mixer_on  = mix_run;
            s.head_up   = up_run;
            s.head_down = down_run;
            awaited_status.push_back(s);
        endfunction

        function void compare_field(string name, logic [3:0] want, logic [3:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [15:0] word);
            status_t want;
            if (awaited_status.size() == 0)
            begin
                $display("%0t: status word %h arrived with nothing expected, expected none, got %h",
                         $time, word, word);
                mismatches++;
                return;
            end
            want = awaited_status.pop_front();
            results_seen++;
            compare_field("phase", want.phase, word[3:0]);
            compare_field("pumps_on", want.pumps_on, word[7:4]);
            compare_field("mixer_on", want.mixer_on, word[8]);
            compare_field("head_up", want.head_up, word[9]);
            compare_field("head_down", want.head_down, word[10]);
            compare_field("start_rejected", want.rejected, word[11]);
            compare_field("zero fill", 4'h0, word[15:12]);
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
// Top level of the timed actuator sequencer testbench: clock, reset, stream drivers.
// Depends on tas_pkg, recipe_check_pkg and the timed_actuator_sequencer RTL.
`timescale 1ns / 1ps

// Every input word yields exactly one status word, by way of the input and
// result registers. Words are predicted the moment the input handshake
// completes, and each status word is checked against the oldest prediction.
// Most of the run feeds whole recipes (start, then ticks until the head is
// back up) with refused starts, unused commands and stops scattered through
// them; a few phases run with the timings at their extremes and are cut short
// by a stop, since a full recipe there would run for tens of thousands of ticks.

module tb_top;
    import tas_pkg::*;
    import recipe_check_pkg::*;

    localparam int WORD_TARGET   = 1700;
    // Longest spell with no word moving on either side before giving up
    localparam int STALL_LIMIT   = 5000;
    // Two-stage pipeline; settle time after draining, before touching registers
    localparam int SETTLE_CYCLES = 8;

    typedef enum {READY_ALWAYS, READY_MOSTLY, READY_PERIODIC, READY_SPARSE} stall_style_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // pump_amount_0, pump_amount_1, pump_amount_2,
                             // pump_amount_3, mix_amount (8 bits each)
    logic [1:0]  s_tuser;    // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // phase, pumps_on, mixer_on, head_up, head_down,
                             // start_rejected, zero fill
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    recipe_scoreboard board;
    int unsigned      words_sent   = 0;
    int unsigned      burst_left   = 0;
    int unsigned      quiet_cycles = 0;

    timed_actuator_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Full 40-bit random payload: every amount bit toggles through these
    function automatic logic [39:0] wide_amounts();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[39:0];
    endfunction

    // Amounts for a recipe that is meant to finish: mostly tiny, rarely full range
    function automatic logic [AMT_BITS-1:0] recipe_amount();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 90)
            return AMT_BITS'($urandom_range(0, 4));
        if (roll < 99)
            return AMT_BITS'($urandom_range(5, 20));
        return AMT_BITS'($urandom_range(0, 255));
    endfunction

    function automatic logic [39:0] recipe_amounts();
        return {recipe_amount(), recipe_amount(), recipe_amount(),
                recipe_amount(), recipe_amount()};
    endfunction

    // Offer one word and hold it until the block takes it. The sender works in
    // bursts; at the start of each burst it may drop valid before offering the word.
    // A rare long burst gives stretches with no gaps at all.
    task automatic send_word(input logic [MODE_BITS-1:0] mode, input logic [39:0] amounts);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = amounts;
        do @(posedge clk); while (!s_tready);
        board.note_word(mode, amounts);
        words_sent++;
    endtask

    // Amounts are ignored on a tick; send noise in them anyway
    task automatic tick();
        send_word(MODE_TICK, wide_amounts());
    endtask

    task automatic settle_to_idle();
        while (board.phase != PH_IDLE)
            tick();
    endtask

    // Drop valid, let every expected status word come back, then allow the pipe to empty
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr  = index;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        board.set_register(index, value);
    endtask

    // Registers change only with nothing in flight
    task automatic set_timings(input logic [CFG_BITS-1:0] scale,
                               input logic [CFG_BITS-1:0] travel,
                               input logic [CFG_BITS-1:0] drip);
        drain();
        write_register(CFG_SCALE, scale);
        write_register(CFG_HEAD, travel);
        write_register(CFG_DRIP, drip);
    endtask

    // One recipe from idle back to idle. Along the way: refused starts with
    // full-range amounts, the unused command and the occasional stop, which
    // sends the head up early from whatever phase it lands in.
    task automatic run_recipe();
        int unsigned roll;
        settle_to_idle();
        roll = $urandom_range(0, 7);
        if (roll == 0)
            tick();
        else if (roll == 1)
            send_word(MODE_UNUSED, wide_amounts());
        else if (roll == 2)
        begin
            send_word(MODE_STOP, wide_amounts());
            settle_to_idle();
        end
        send_word(MODE_START, recipe_amounts());
        while (board.phase != PH_IDLE)
        begin
            roll = $urandom_range(0, 199);
            if (roll < 6)
                send_word(MODE_START, wide_amounts());
            else if (roll < 9)
                send_word(MODE_UNUSED, wide_amounts());
            else if (roll < 11)
                send_word(MODE_STOP, wide_amounts());
            else
                tick();
        end
    endtask

    // Start under extreme timings, run a while, then stop. The stop is the last
    // word so the head travel loads from the next setting.
    task automatic run_aborted(input int unsigned length);
        int unsigned n;
        int unsigned roll;
        settle_to_idle();
        send_word(MODE_START, wide_amounts());
        for (n = 0; n < length; n++)
        begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                send_word(MODE_START, wide_amounts());
            else if (roll == 1)
                send_word(MODE_UNUSED, wide_amounts());
            else
                tick();
        end
        send_word(MODE_STOP, wide_amounts());
    endtask

    // Receiver: ready follows one of a few patterns, each held for a random stretch
    initial
    begin
        int unsigned  stretch;
        int unsigned  period;
        int unsigned  count;
        stall_style_t style;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stretch = $urandom_range(20, 200);
            style   = stall_style_t'($urandom_range(0, 3));
            period  = $urandom_range(2, 5);
            for (count = 0; count < stretch; count++)
            begin
                @(negedge clk);
                case (style)
                    READY_ALWAYS:   m_tready = 1'b1;
                    READY_MOSTLY:   m_tready = ($urandom_range(0, 3) != 0);
                    READY_PERIODIC: m_tready = (count % period == 0);
                    default:        m_tready = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Check every status word the block hands over, and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL timed_actuator_sequencer");
                $finish;
            end
        end
    end

    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_TICK;
        cfg_wr_en = 1'b0;
        cfg_addr  = CFG_SCALE;
        cfg_wdata = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset timings: idle tick, unused command, a start, two ticks, a refused start, stop
        send_word(MODE_TICK, '0);
        send_word(MODE_UNUSED, '1);
        send_word(MODE_START, {8'd1, 8'hFF, 8'h00, 8'hAA, 8'h55});
        send_word(MODE_TICK, '0);
        send_word(MODE_TICK, '0);
        send_word(MODE_START, {8'hFE, 8'h01, 8'h55, 8'hAA, 8'h00});
        send_word(MODE_STOP, '0);

        // Shortest timings: zero head travel and drip, one tick per unit
        set_timings(16'd1, 16'd0, 16'd0);
        settle_to_idle();
        send_word(MODE_START, {8'd1, 8'd0, 8'd2, 8'd1, 8'd0});
        settle_to_idle();

        // Rotate through settings until enough words have gone in
        while (words_sent < WORD_TARGET)
        begin
            set_timings(16'd1, 16'd0, 16'd0);
            repeat ($urandom_range(2, 5)) run_recipe();

            set_timings(16'($urandom_range(1, 3)), 16'($urandom_range(0, 4)),
                        16'($urandom_range(0, 6)));
            repeat ($urandom_range(2, 5)) run_recipe();

            set_timings(16'hFFFF, 16'd0, 16'd0);
            run_aborted($urandom_range(20, 60));

            set_timings(16'($urandom_range(1, 3)), 16'($urandom_range(0, 4)),
                        16'($urandom_range(0, 6)));
            repeat ($urandom_range(2, 5)) run_recipe();

            set_timings(16'd3, 16'hFFFF, 16'hFFFF);
            run_aborted($urandom_range(20, 60));

            set_timings(16'($urandom_range(1, 2)), 16'd1, 16'd2);
            repeat ($urandom_range(2, 5)) run_recipe();
        end

        drain();
        $display("Sent %0d words, checked %0d status words: %0d starts taken, %0d refused, %0d stops",
                 words_sent, board.results_seen, board.starts_taken, board.starts_refused,
                 board.stops_seen);
        $display("%0d recipes ran back to idle; scale 1..65535, head and drip 0..65535 ticks",
                 board.recipes_done);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS timed_actuator_sequencer");
        else
            $display("FAIL timed_actuator_sequencer");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/tas_pkg.sv
rtl/core/tas_scale.sv
rtl/core/tas_pump.sv
rtl/core/timed_actuator_sequencer.sv
tb/recipe_check_pkg.sv
tb/tb_top.sv
